/* rtl/mme_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types, widths, codes and helpers of the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int unsigned DIM_W   = 4;
  localparam int unsigned POS_W   = 3;
  localparam int unsigned ADDR_W  = 6;
  localparam int unsigned SIZE_W  = 7;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned PROD_W  = 32;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned DEPTH   = 64;

  localparam logic [DIM_W-1:0] MAX_DIM = 4'd8;

  localparam logic [OP_W-1:0] OP_WR_A    = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_B    = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_A_ROWS = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_A_COLS = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_B_ROWS = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_B_COLS = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic issue;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic start_ok;
    logic k_last;
    logic ac_zero;
    logic pipe_busy;
    logic elem_last;
    logic out_free;
  } status_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] raw);
    return (raw > MAX_DIM) ? MAX_DIM : raw;
  endfunction

endpackage
`default_nettype wire

/* rtl/mme_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mme_in_if
// Input channel: element loads and compute requests.
// ----------------------------------------------------------------------------
interface mme_in_if;
  logic                          valid;
  logic                          ready;
  logic [mme_pkg::OP_W-1:0]      op;
  logic [mme_pkg::ADDR_W-1:0]    element_index;
  logic signed [mme_pkg::VAL_W-1:0] element_value;

  modport source (output valid, output op, output element_index, output element_value,
                  input ready);
  modport sink   (input valid, input op, input element_index, input element_value,
                  output ready);
endinterface
`default_nettype wire

/* rtl/mme_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mme_out_if
// Result channel: one product element per transaction.
// ----------------------------------------------------------------------------
interface mme_out_if;
  logic                             valid;
  logic                             ready;
  logic [mme_pkg::POS_W-1:0]        out_row;
  logic [mme_pkg::POS_W-1:0]        out_col;
  logic signed [mme_pkg::SUM_W-1:0] product_value;
  logic                             last;

  modport source (output valid, output out_row, output out_col, output product_value,
                  output last, input ready);
  modport sink   (input valid, input out_row, input out_col, input product_value,
                  input last, output ready);
endinterface
`default_nettype wire

/* rtl/matrix_multiply_engine.sv */
// Loads stream one per cycle while the engine is idle. A compute item is
// taken, then each of the a_row_count * b_col_count product elements gets
// a_col_count multiply-accumulate steps (none if a_col_count is 0), a drain
// of the read, multiply and add pipeline and a load of the result register.
// Result stalls hold this up; input is held off until the last element loads.
// Reset (synchronous, rst_n low) idles, empties the result, sets dims to 8.
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Dense Q8.8 matrix multiply over two local element stores.
// ----------------------------------------------------------------------------
module matrix_multiply_engine (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  mme_in_if.sink                           in_chan,
  mme_out_if.source                        out_chan,
  input  wire logic                        cfg_wr_en,
  input  wire logic [mme_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [mme_pkg::DIM_W-1:0]   cfg_wdata
);

  mme_pkg::cmd_t    cmd;
  mme_pkg::status_t status;
  logic             in_ready;

  assign in_chan.ready = in_ready;

  mme_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mme_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_op     (in_chan.op),
    .in_index  (in_chan.element_index),
    .in_value  (in_chan.element_value),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_row   (out_chan.out_row),
    .out_col   (out_chan.out_col),
    .out_value (out_chan.product_value),
    .out_last  (out_chan.last)
  );

endmodule
`default_nettype wire

/* rtl/mme_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mme_ctrl
// Sequencer: accepts items, steps the multiply-accumulate and emits results.
// ----------------------------------------------------------------------------
module mme_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire mme_pkg::status_t status,
  output mme_pkg::cmd_t         cmd
);

  mme_pkg::state_t state_r;
  mme_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mme_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mme_pkg::ST_IDLE: begin
        if (in_valid && status.start_ok) begin
          state_nxt = status.ac_zero ? mme_pkg::ST_DRAIN : mme_pkg::ST_MAC;
        end
      end
      mme_pkg::ST_MAC: begin
        if (status.k_last) begin
          state_nxt = mme_pkg::ST_DRAIN;
        end
      end
      mme_pkg::ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = mme_pkg::ST_EMIT;
        end
      end
      mme_pkg::ST_EMIT: begin
        if (status.out_free) begin
          if (status.elem_last) begin
            state_nxt = mme_pkg::ST_IDLE;
          end else if (status.ac_zero) begin
            state_nxt = mme_pkg::ST_DRAIN;
          end else begin
            state_nxt = mme_pkg::ST_MAC;
          end
        end
      end
      default: state_nxt = mme_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      mme_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        cmd.start  = in_valid && status.start_ok;
      end
      mme_pkg::ST_MAC: begin
        cmd.issue = 1'b1;
      end
      mme_pkg::ST_DRAIN: begin
        cmd = '0;
      end
      mme_pkg::ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/mme_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mme_datapath
// Element stores, dimension registers, address walk, multiply-accumulate
// pipeline and the result register.
// ----------------------------------------------------------------------------
module mme_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [mme_pkg::CIDX_W-1:0]         cfg_index,
  input  wire logic [mme_pkg::DIM_W-1:0]          cfg_wdata,
  input  wire logic [mme_pkg::OP_W-1:0]           in_op,
  input  wire logic [mme_pkg::ADDR_W-1:0]         in_index,
  input  wire logic signed [mme_pkg::VAL_W-1:0]   in_value,
  input  wire mme_pkg::cmd_t                      cmd,
  output mme_pkg::status_t                        status,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [mme_pkg::POS_W-1:0]               out_row,
  output logic [mme_pkg::POS_W-1:0]               out_col,
  output logic signed [mme_pkg::SUM_W-1:0]        out_value,
  output logic                                    out_last
);

  logic [mme_pkg::DIM_W-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic [mme_pkg::DIM_W-1:0] ar, ac, br, bc;
  logic [mme_pkg::SIZE_W-1:0] a_size, b_size;

  logic signed [mme_pkg::VAL_W-1:0] a_mem [mme_pkg::DEPTH];
  logic signed [mme_pkg::VAL_W-1:0] b_mem [mme_pkg::DEPTH];

  logic [mme_pkg::POS_W-1:0]  i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [mme_pkg::ADDR_W-1:0] a_base_r, a_base_nxt, a_addr_r, a_addr_nxt;
  logic [mme_pkg::ADDR_W-1:0] b_addr_r, b_addr_nxt;
  logic                       row_end;

  logic signed [mme_pkg::VAL_W-1:0]  a_rd_r, b_rd_r;
  logic signed [mme_pkg::PROD_W-1:0] mul_r;
  logic signed [mme_pkg::SUM_W-1:0]  acc_r, acc_nxt;
  logic                              rd_v_r, mul_v_r;

  logic                              out_valid_r, out_valid_nxt;
  logic [mme_pkg::POS_W-1:0]         out_row_r, out_col_r;
  logic signed [mme_pkg::SUM_W-1:0]  out_value_r;
  logic                              out_last_r;

  // Dimension registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= mme_pkg::MAX_DIM;
      a_cols_r <= mme_pkg::MAX_DIM;
      b_rows_r <= mme_pkg::MAX_DIM;
      b_cols_r <= mme_pkg::MAX_DIM;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mme_pkg::CFG_A_ROWS: a_rows_r <= cfg_wdata;
        mme_pkg::CFG_A_COLS: a_cols_r <= cfg_wdata;
        mme_pkg::CFG_B_ROWS: b_rows_r <= cfg_wdata;
        mme_pkg::CFG_B_COLS: b_cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign ar = mme_pkg::eff_dim(a_rows_r);
  assign ac = mme_pkg::eff_dim(a_cols_r);
  assign br = mme_pkg::eff_dim(b_rows_r);
  assign bc = mme_pkg::eff_dim(b_cols_r);

  assign a_size = {3'b000, ar} * {3'b000, ac};
  assign b_size = {3'b000, br} * {3'b000, bc};

  // Stores: loads write while idle, the walk reads while computing.
  always_ff @(posedge clk) begin
    if (cmd.accept && (in_op == mme_pkg::OP_WR_A) && ({1'b0, in_index} < a_size)) begin
      a_mem[in_index] <= in_value;
    end
    if (cmd.issue) begin
      a_rd_r <= a_mem[a_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (in_op == mme_pkg::OP_WR_B) && ({1'b0, in_index} < b_size)) begin
      b_mem[in_index] <= in_value;
    end
    if (cmd.issue) begin
      b_rd_r <= b_mem[b_addr_r];
    end
  end

  // Address walk: A runs along a row, B steps down a column by its stride.
  assign row_end = ({1'b0, j_r} == (bc - 4'd1));

  always_comb begin
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    a_base_nxt = a_base_r;
    a_addr_nxt = a_addr_r;
    b_addr_nxt = b_addr_r;
    if (cmd.start) begin
      i_nxt      = '0;
      j_nxt      = '0;
      k_nxt      = '0;
      a_base_nxt = '0;
      a_addr_nxt = '0;
      b_addr_nxt = '0;
    end else if (cmd.issue) begin
      k_nxt      = k_r + 3'd1;
      a_addr_nxt = a_addr_r + 6'd1;
      b_addr_nxt = b_addr_r + {2'b00, bc};
    end else if (cmd.emit) begin
      k_nxt = '0;
      if (row_end) begin
        i_nxt      = i_r + 3'd1;
        j_nxt      = '0;
        a_base_nxt = a_base_r + {2'b00, ac};
      end else begin
        j_nxt = j_r + 3'd1;
      end
      a_addr_nxt = a_base_nxt;
      b_addr_nxt = {3'b000, j_nxt};
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    a_base_r <= a_base_nxt;
    a_addr_r <= a_addr_nxt;
    b_addr_r <= b_addr_nxt;
  end

  // Multiply-accumulate pipeline: read, multiply, add.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      rd_v_r  <= cmd.issue;
      mul_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      mul_r <= a_rd_r * b_rd_r;
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.start || cmd.emit) begin
      acc_nxt = '0;
    end else if (mul_v_r) begin
      acc_nxt = acc_r + {{(mme_pkg::SUM_W - mme_pkg::PROD_W){mul_r[mme_pkg::PROD_W-1]}}, mul_r};
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Result register.
  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row_r   <= i_r;
      out_col_r   <= j_r;
      out_value_r <= acc_r;
      out_last_r  <= status.elem_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  always_comb begin
    status.start_ok  = (in_op == mme_pkg::OP_COMPUTE) && (ac == br) &&
                       (ar != '0) && (bc != '0);
    status.k_last    = ({1'b0, k_r} == (ac - 4'd1));
    status.ac_zero   = (ac == '0);
    status.pipe_busy = rd_v_r || mul_v_r;
    status.elem_last = ({1'b0, i_r} == (ar - 4'd1)) && row_end;
    status.out_free  = !out_valid_r || out_ready;
  end

endmodule
`default_nettype wire

/* rtl/mme_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mme_checker
// Port-level checks of the matrix multiply engine, bound to the top level.
// ----------------------------------------------------------------------------
module mme_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic [mme_pkg::OP_W-1:0]         in_op,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic signed [mme_pkg::SUM_W-1:0] out_value,
  input wire logic                             out_last
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
    else $error("stalled result changed");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // While a run still has elements to come, no new item is taken.
  a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken in the middle of a compute run");

  // An element load never produces a result.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid &&
    (in_op == mme_pkg::OP_WR_A || in_op == mme_pkg::OP_WR_B) |=> !out_valid)
    else $error("element load produced a result");

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_op     (in_chan.op),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_value (out_chan.product_value),
  .out_last  (out_chan.last)
);
`default_nettype wire

/* bench/mme_product_check.sv */
// ----------------------------------------------------------------------------
// mme_product_check
// Watches the load/compute channel, the configuration port and the result
// channel of the matrix multiply engine. It keeps its own copy of both element
// stores and of the four dimension registers. It queues the product elements
// that each compute transaction must produce and compares every result
// transaction against the oldest one.
// ----------------------------------------------------------------------------
module mme_product_check
  import mme_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  mme_in_if                 in_chan,
  mme_out_if                out_chan,
  input  logic              cfg_wr_en,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]  cfg_wdata,
  output int                miss_count,
  output int                pending_elems
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic signed [SUM_W-1:0] value;
    logic                    last;
  } product_elem_t;

  logic signed [VAL_W-1:0] a_mem [DEPTH];
  logic signed [VAL_W-1:0] b_mem [DEPTH];
  logic [DIM_W-1:0]        a_rows, a_cols, b_rows, b_cols;
  product_elem_t           product_q [$];
  int                      errors = 0;

  initial begin
    miss_count    = 0;
    pending_elems = 0;
  end

  // A register value above the largest dimension behaves as the largest one.
  function automatic int unsigned limit_dim(input logic [DIM_W-1:0] raw);
    return (raw > MAX_DIM) ? int'(MAX_DIM) : int'(raw);
  endfunction

  function automatic void apply_item(input logic [OP_W-1:0]       op,
                                     input logic [ADDR_W-1:0]     idx,
                                     input logic signed [VAL_W-1:0] val);
    int unsigned   ar, ac, br, bc, total, seen;
    longint        acc;
    product_elem_t elem;
    ar = limit_dim(a_rows);
    ac = limit_dim(a_cols);
    br = limit_dim(b_rows);
    bc = limit_dim(b_cols);
    case (op)
      OP_WR_A: begin
        if (idx < ar * ac) a_mem[idx] = val;
      end
      OP_WR_B: begin
        if (idx < br * bc) b_mem[idx] = val;
      end
      OP_COMPUTE: begin
        // A shape mismatch produces no elements at all.
        if (ac == br) begin
          total = ar * bc;
          seen  = 0;
          for (int unsigned i = 0; i < ar; i++) begin
            for (int unsigned j = 0; j < bc; j++) begin
              acc = 0;
              for (int unsigned k = 0; k < ac; k++) begin
                acc += longint'(a_mem[(i * ac + k) % DEPTH]) *
                       longint'(b_mem[(k * bc + j) % DEPTH]);
              end
              seen++;
              elem.row   = POS_W'(i);
              elem.col   = POS_W'(j);
              elem.value = acc[SUM_W-1:0];
              elem.last  = (seen == total);
              product_q.push_back(elem);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    product_elem_t got;
    product_elem_t want;
    if (!rst_n) begin
      a_rows = MAX_DIM;
      a_cols = MAX_DIM;
      b_rows = MAX_DIM;
      b_cols = MAX_DIM;
      product_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_A_ROWS: a_rows = cfg_wdata;
          CFG_A_COLS: a_cols = cfg_wdata;
          CFG_B_ROWS: b_rows = cfg_wdata;
          CFG_B_COLS: b_cols = cfg_wdata;
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready) begin
        apply_item(in_chan.op, in_chan.element_index, in_chan.element_value);
      end
      if (out_chan.valid && out_chan.ready) begin
        got.row   = out_chan.out_row;
        got.col   = out_chan.out_col;
        got.value = out_chan.product_value;
        got.last  = out_chan.last;
        if (product_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("unexpected product element: row %0d col %0d value %0d last %0b",
                     got.row, got.col, got.value, got.last);
          end
        end else begin
          want = product_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("product mismatch: expected row %0d col %0d value %0d last %0b",
                       want.row, want.col, want.value, want.last);
              $display("                  actual   row %0d col %0d value %0d last %0b",
                       got.row, got.col, got.value, got.last);
            end
          end
        end
      end
    end
    miss_count    <= errors;
    pending_elems <= product_q.size();
  end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the matrix multiply engine. A directed opening covers extreme
// element values, ignored loads, the unused opcode, shape mismatch and empty
// dimensions. Phases of loads and computes with random content follow, over
// several matrix shapes and idling patterns. One phase holds the result
// channel off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
  import mme_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam logic [CIDX_W-1:0] CFG_ORDER [4] = '{CFG_A_ROWS, CFG_A_COLS,
                                                  CFG_B_ROWS, CFG_B_COLS};
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned SETTLE_CYCLES  = 64;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS   = 90;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [CIDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]  cfg_wdata;
  int                miss_count;
  int                pending_elems;

  mme_in_if  in_chan ();
  mme_out_if out_chan ();

  // Stimulus-side view of the shape and of which store entries hold data.
  logic [DIM_W-1:0] dims [4];
  bit               written_a [DEPTH];
  bit               written_b [DEPTH];
  int unsigned      idle_pct = 0;
  int unsigned      stall_pct = 0;
  int unsigned      hold_seq = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      counted = 0;

  always #5 clk = ~clk;

  matrix_multiply_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  mme_product_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_chan       (in_chan),
    .out_chan      (out_chan),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .miss_count    (miss_count),
    .pending_elems (pending_elems)
  );

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] raw);
    return (raw > MAX_DIM) ? int'(MAX_DIM) : int'(raw);
  endfunction

  function automatic int unsigned elem_count(input bit of_b);
    if (of_b) return clamp_dim(dims[CFG_B_ROWS]) * clamp_dim(dims[CFG_B_COLS]);
    return clamp_dim(dims[CFG_A_ROWS]) * clamp_dim(dims[CFG_A_COLS]);
  endfunction

  // Offers one transaction and returns at the edge where it is taken.
  task automatic send(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] idx,
                      input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.op            <= op;
    in_chan.element_index <= idx;
    in_chan.element_value <= val;
    do @(posedge clk); while (!in_chan.ready);
    if (op == OP_WR_A && idx < elem_count(1'b0)) begin
      written_a[idx] = 1'b1;
      counted++;
    end else if (op == OP_WR_B && idx < elem_count(1'b1)) begin
      written_b[idx] = 1'b1;
      counted++;
    end else if (op == OP_COMPUTE) begin
      counted++;
    end
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_elems != 0) @(posedge clk);
  endtask

  // Registers change only with the engine idle, so wait out any compute that
  // produced nothing before writing.
  task automatic set_dims(input logic [DIM_W-1:0] ar, input logic [DIM_W-1:0] ac,
                          input logic [DIM_W-1:0] br, input logic [DIM_W-1:0] bc);
    logic [DIM_W-1:0] vals [4];
    vals = '{ar, ac, br, bc};
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int r = 0; r < 4; r++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_ORDER[r];
      cfg_wdata <= vals[r];
      dims[CFG_ORDER[r]] = vals[r];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Fills any entry a compute would read that has never been loaded.
  task automatic compute_safe();
    int unsigned ar, ac, br, bc;
    ar = clamp_dim(dims[CFG_A_ROWS]);
    ac = clamp_dim(dims[CFG_A_COLS]);
    br = clamp_dim(dims[CFG_B_ROWS]);
    bc = clamp_dim(dims[CFG_B_COLS]);
    if (ac == br && ar * bc != 0) begin
      for (int unsigned i = 0; i < ar * ac; i++) begin
        if (!written_a[i]) send(OP_WR_A, ADDR_W'(i), VAL_W'($urandom));
      end
      for (int unsigned i = 0; i < br * bc; i++) begin
        if (!written_b[i]) send(OP_WR_B, ADDR_W'(i), VAL_W'($urandom));
      end
    end
    send(OP_COMPUTE, ADDR_W'($urandom_range(63)), VAL_W'($urandom));
  endtask

  // Result-side ready, with an occasional long hold-off on request.
  initial begin
    int unsigned hold_left;
    int unsigned seen_seq;
    hold_left = 0;
    seen_seq  = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [DIM_W-1:0] d [4];
    int unsigned      n_ops;
    int unsigned      pick;
    int unsigned      na;
    int unsigned      nb;
    rst_n                 <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.op            <= OP_WR_A;
    in_chan.element_index <= '0;
    in_chan.element_value <= '0;
    cfg_wr_en             <= 1'b0;
    cfg_index             <= CFG_A_ROWS;
    cfg_wdata             <= '0;
    for (int r = 0; r < 4; r++) dims[r] = MAX_DIM;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // 2x2 by 2x2 with the most positive and most negative element values.
    set_dims(4'd2, 4'd2, 4'd2, 4'd2);
    send(OP_WR_A, 6'd0, 16'h7FFF);
    send(OP_WR_A, 6'd1, 16'h8000);
    send(OP_WR_A, 6'd2, 16'hFFFF);
    send(OP_WR_A, 6'd3, 16'h0001);
    send(OP_WR_A, 6'd4, 16'h1234);
    send(OP_WR_B, 6'd0, 16'h8000);
    send(OP_WR_B, 6'd1, 16'h7FFF);
    send(OP_WR_B, 6'd2, 16'h8000);
    send(OP_WR_B, 6'd3, 16'h0100);
    send(OP_WR_B, 6'd63, 16'hFFFF);
    send(OP_NONE, 6'd63, 16'hFFFF);
    send(OP_COMPUTE, 6'd0, 16'h0000);
    // Inner dimensions disagree.
    set_dims(4'd2, 4'd3, 4'd2, 4'd2);
    send(OP_COMPUTE, 6'd63, 16'hFFFF);
    // A has no rows: loads into A are dropped and the product is empty.
    set_dims(4'd0, 4'd2, 4'd2, 4'd3);
    send(OP_WR_A, 6'd0, 16'h5555);
    send(OP_COMPUTE, 6'd0, 16'h0000);
    // Empty inner dimension: every product element is a sum of nothing.
    set_dims(4'd3, 4'd0, 4'd0, 4'd2);
    send(OP_WR_B, 6'd0, 16'hAAAA);
    send(OP_COMPUTE, 6'd0, 16'h0000);

    counted = 0;
    for (int p = 0; p < 4 || counted < RANDOM_ITEMS; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 56; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 56; end
        default: begin idle_pct = 35; stall_pct <= 35; end
      endcase
      case (p)
        0: d = '{4'd1, 4'd1, 4'd1, 4'd1};
        1: d = '{4'd9, 4'd1, 4'd1, 4'd15};
        2: d = '{4'd1, 4'd8, 4'd8, 4'd1};
        3: d = '{4'd2, 4'd9, 4'd12, 4'd2};
        default: begin
          d[0] = DIM_W'($urandom_range(1, 4));
          d[1] = DIM_W'($urandom_range(1, 4));
          d[3] = DIM_W'($urandom_range(1, 4));
          d[2] = ($urandom_range(4) == 0) ? DIM_W'($urandom_range(1, 4)) : d[1];
          if ($urandom_range(5) == 0) begin
            d[$urandom_range(3)] = $urandom_range(1) ? DIM_W'(0)
                                                     : DIM_W'($urandom_range(9, 15));
          end
        end
      endcase
      set_dims(d[0], d[1], d[2], d[3]);
      na = elem_count(1'b0);
      nb = elem_count(1'b1);
      for (int unsigned i = 0; i < na; i++) send(OP_WR_A, ADDR_W'(i), VAL_W'($urandom));
      for (int unsigned i = 0; i < nb; i++) send(OP_WR_B, ADDR_W'(i), VAL_W'($urandom));
      // 64 results against a stalled receiver back the engine up into its input.
      if (p == 1) begin
        hold_seq <= hold_seq + 1;
        compute_safe();
      end
      n_ops = $urandom_range(6, 14);
      repeat (n_ops) begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          compute_safe();
        end else if (pick < 60) begin
          send(OP_WR_A, ADDR_W'(na != 0 ? $urandom_range(na - 1) : $urandom_range(63)),
               VAL_W'($urandom));
        end else if (pick < 85) begin
          send(OP_WR_B, ADDR_W'(nb != 0 ? $urandom_range(nb - 1) : $urandom_range(63)),
               VAL_W'($urandom));
        end else if (pick < 95) begin
          send($urandom_range(1) ? OP_WR_B : OP_WR_A, ADDR_W'($urandom_range(63)),
               VAL_W'($urandom));
        end else begin
          send(OP_NONE, ADDR_W'($urandom_range(63)), VAL_W'($urandom));
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (miss_count == 0 && pending_elems == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/mme_pkg.sv
rtl/mme_in_if.sv
rtl/mme_out_if.sv
rtl/mme_ctrl.sv
rtl/mme_datapath.sv
rtl/matrix_multiply_engine.sv
rtl/mme_checker.sv
bench/mme_product_check.sv
bench/tb.sv
